// ===== design/page_frame_stack_allocator_macros.svh =====
// Assertion macros for the page frame stack allocator.
`ifndef PAGE_FRAME_STACK_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_STACK_ALLOCATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PFSA_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

`define PFSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`define PFSA_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("%m: check failed");

`else

`define PFSA_ASSERT_IMPLY(lbl, ante, cons)
`define PFSA_ASSERT_NEXT(lbl, ante, cons)
`define PFSA_ASSERT_NEVER(lbl, expr)

`endif

`endif

// ===== design/pfsa_pkg.sv =====
// Types and constants of the page frame stack allocator.
package pfsa_pkg;

  localparam int PAGE_SHIFT    = 12;
  localparam int LOW_LIMIT_PFN = (32'hfffff + 1) >> PAGE_SHIFT;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_STORE_START  = 2'd0,
    CFG_STORE_END    = 2'd1,
    CFG_KERNEL_FIRST = 2'd2,
    CFG_KERNEL_LAST  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_ALLOC
  } state_e;

endpackage

// ===== design/pfsa_ram.sv =====
// Single-port-write, single-port-read RAM with registered read data.
module pfsa_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/page_frame_stack_allocator.sv =====
// Free, cmd 3, unusable region and empty alloc give the result strobe in the cycle after
// accept; alloc strobes after ST_ALLOC reads the stack RAM; add region walks pages through the
// single compare/increment unit, one page pushed or excluded span skipped per cycle.
// A new item is accepted in the cycle its predecessor's result is strobed.
// Reset clears the free count and the config registers; stack contents stay undefined,
// no clearing pass. Results are strobed for one cycle; the receiver cannot stall.
`include "page_frame_stack_allocator_macros.svh"

module page_frame_stack_allocator #(
  parameter int STACK_DEPTH = 4096,
  parameter int ADDR_BITS   = 48
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  output logic                             done_o,
  input  logic [1:0]                       cmd_i,
  input  logic [ADDR_BITS-1:0]             region_base_i,
  input  logic [ADDR_BITS-1:0]             region_length_i,
  input  logic                             region_usable_i,
  input  logic [ADDR_BITS-1:0]             freed_address_i,
  output logic [ADDR_BITS-1:0]             page_address_o,
  output logic [1:0]                       status_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0] free_count_o,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_idx_i,
  input  logic [ADDR_BITS-1:0]             cfg_data_i
);

  localparam int PS    = pfsa_pkg::PAGE_SHIFT;
  localparam int PFN_W = ADDR_BITS - PS;
  localparam int P_W   = PFN_W + 1;
  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);
  localparam logic [P_W-1:0]   LOW_PFN   = P_W'(pfsa_pkg::LOW_LIMIT_PFN);
  localparam logic [P_W-1:0]   LIMIT_PFN = {1'b1, {PFN_W{1'b0}}};
  localparam logic [PS+1:0]    ROUND_UP  = {2'b00, {PS{1'b1}}};

  // config registers
  logic [ADDR_BITS-1:0] store_start_q, store_end_q, kernel_first_q, kernel_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_start_q  <= '0;
      store_end_q    <= '0;
      kernel_first_q <= '0;
      kernel_last_q  <= '0;
    end else if (cfg_we_i) begin
      case (pfsa_pkg::cfg_idx_e'(cfg_idx_i))
        pfsa_pkg::CFG_STORE_START:  store_start_q  <= cfg_data_i;
        pfsa_pkg::CFG_STORE_END:    store_end_q    <= cfg_data_i;
        pfsa_pkg::CFG_KERNEL_FIRST: kernel_first_q <= cfg_data_i;
        pfsa_pkg::CFG_KERNEL_LAST:  kernel_last_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Inclusive byte range to pages, first rounded up, last holding e: {valid, first pfn, last pfn}.
  function automatic logic [2*P_W:0] span_f(input logic [ADDR_BITS-1:0] s,
                                            input logic [ADDR_BITS-1:0] e);
    logic [P_W-1:0] lo;
    logic [P_W-1:0] hi;
    logic           ok;
    lo = P_W'(s >> PS) + P_W'(s[PS-1:0] != '0);
    hi = P_W'(e >> PS);
    ok = (s <= e) && (lo <= hi);
    return {ok, lo, hi};
  endfunction

  logic           sv_q, kv_q;
  logic [P_W-1:0] sl_q, sh_q, kl_q, kh_q;

  // spans are registered from the config registers and follow them in the next cycle
  always_ff @(posedge clk_i) begin
    {sv_q, sl_q, sh_q} <= span_f(store_start_q, store_end_q);
    {kv_q, kl_q, kh_q} <= span_f(kernel_first_q, kernel_last_q);
  end

  // region end page, rounded up and clamped to the address space; start page clamped to the low limit
  logic [PS+1:0]  round_sum;
  logic [P_W:0]   endp_sum;
  logic [P_W-1:0] endp_start, base_pfn, p_start;

  always_comb begin
    round_sum  = {2'b00, region_base_i[PS-1:0]} + {2'b00, region_length_i[PS-1:0]} + ROUND_UP;
    endp_sum   = (P_W+1)'(region_base_i >> PS) + (P_W+1)'(region_length_i >> PS)
               + (P_W+1)'(round_sum[PS+1:PS]);
    endp_start = (endp_sum > {1'b0, LIMIT_PFN}) ? LIMIT_PFN : endp_sum[P_W-1:0];
    base_pfn   = P_W'(region_base_i >> PS);
    p_start    = (base_pfn < LOW_PFN) ? LOW_PFN : base_pfn;
  end

  pfsa_pkg::state_e  state_q, state_d;
  pfsa_pkg::status_e status_q, status_d;
  logic [P_W-1:0]       p_q, p_d, endp_q, endp_d;
  logic [CNT_W-1:0]     top_q, top_d;
  logic [ADDR_BITS-1:0] page_q, page_d;
  logic                 done_q, done_d;

  logic             ram_we;
  logic [PFN_W-1:0] ram_wdata, ram_rdata;
  logic [CNT_W-1:0] top_dec;
  logic             full;

  // shared walk unit: exclusion compare and one incrementer
  logic           hit_s, hit_k, at_end;
  logic [P_W-1:0] step_base, step_next;

  always_comb begin
    hit_s     = sv_q && (p_q >= sl_q) && (p_q <= sh_q);
    hit_k     = kv_q && (p_q >= kl_q) && (p_q <= kh_q);
    at_end    = p_q >= endp_q;
    step_base = hit_s ? sh_q : (hit_k ? kh_q : p_q);
    step_next = step_base + P_W'(1);
    top_dec   = top_q - CNT_W'(1);
    full      = top_q == DEPTH_CNT;
  end

  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    p_d       = p_q;
    endp_d    = endp_q;
    top_d     = top_q;
    page_d    = page_q;
    done_d    = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = p_q[PFN_W-1:0];

    case (state_q)
      pfsa_pkg::ST_IDLE: begin
        if (start) begin
          page_d   = '0;
          status_d = pfsa_pkg::STAT_OK;
          case (pfsa_pkg::cmd_e'(cmd_i))
            pfsa_pkg::CMD_ADD: begin
              if (region_usable_i) begin
                p_d     = p_start;
                endp_d  = endp_start;
                state_d = pfsa_pkg::ST_WALK;
              end else begin
                done_d = 1'b1;
              end
            end
            pfsa_pkg::CMD_ALLOC: begin
              if (top_q == '0) begin
                status_d = pfsa_pkg::STAT_EMPTY;
                done_d   = 1'b1;
              end else begin
                top_d   = top_dec;
                state_d = pfsa_pkg::ST_ALLOC;
              end
            end
            pfsa_pkg::CMD_FREE: begin
              ram_wdata = PFN_W'(freed_address_i >> PS);
              if (freed_address_i != '0) begin
                if (full) begin
                  status_d = pfsa_pkg::STAT_FULL;
                end else begin
                  ram_we = 1'b1;
                  top_d  = top_q + CNT_W'(1);
                end
              end
              done_d = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      pfsa_pkg::ST_WALK: begin
        if (at_end) begin
          done_d  = 1'b1;
          state_d = pfsa_pkg::ST_IDLE;
        end else if (hit_s || hit_k) begin
          // jump past the excluded span
          p_d = step_next;
        end else if (full) begin
          status_d = pfsa_pkg::STAT_FULL;
          done_d   = 1'b1;
          state_d  = pfsa_pkg::ST_IDLE;
        end else begin
          ram_we = 1'b1;
          top_d  = top_q + CNT_W'(1);
          p_d    = step_next;
        end
      end
      pfsa_pkg::ST_ALLOC: begin
        page_d  = {ram_rdata, {PS{1'b0}}};
        done_d  = 1'b1;
        state_d = pfsa_pkg::ST_IDLE;
      end
      default: begin
        state_d = pfsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pfsa_pkg::ST_IDLE;
      status_q <= pfsa_pkg::STAT_OK;
      top_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      top_q    <= top_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    endp_q <= endp_d;
    page_q <= page_d;
  end

  pfsa_ram #(
    .WIDTH (PFN_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (top_q[IDX_W-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (top_dec[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign busy           = state_q != pfsa_pkg::ST_IDLE;
  assign done_o         = done_q;
  assign page_address_o = page_q;
  assign status_o       = status_q;
  assign free_count_o   = top_q;

  `PFSA_ASSERT_NEVER(a_top_in_range, top_q > DEPTH_CNT)
  `PFSA_ASSERT_IMPLY(a_no_write_when_full, ram_we, top_q < DEPTH_CNT)
  `PFSA_ASSERT_IMPLY(a_done_only_idle, done_q, state_q == pfsa_pkg::ST_IDLE)
  `PFSA_ASSERT_NEXT(a_alloc_completes, state_q == pfsa_pkg::ST_ALLOC,
                    done_q && status_q == pfsa_pkg::STAT_OK)

endmodule

// ===== verif/tb_page_frame_stack_allocator.sv =====
// Testbench for the page frame stack allocator: command stimulus with a mirrored free-page stack.
module tb_page_frame_stack_allocator;

  localparam int          STACK_DEPTH   = 4096;
  localparam int          ADDR_BITS     = 48;
  localparam int          WATCHDOG      = 20000;
  localparam int          SETTLE_CYCLES = 4;
  localparam logic [47:0] ADDR_TOP      = 48'hffff_ffff_ffff;
  localparam logic [63:0] PFN_LIMIT     = 64'h10_0000_0000;
  localparam logic [63:0] LOW_PFN       = 64'(pfsa_pkg::LOW_LIMIT_PFN);

  typedef struct packed {
    pfsa_pkg::cmd_e cmd;
    logic [47:0]    base;
    logic [47:0]    len;
    logic           usable;
    logic [47:0]    freed;
  } request_t;

  typedef struct packed {
    logic [47:0]       page;
    pfsa_pkg::status_e status;
    logic [12:0]       count;
  } grant_t;

  // Mirror of the free-page stack; predicts one grant per accepted command.
  class frame_stack_mirror;
    logic [35:0] frames [STACK_DEPTH];
    int unsigned depth_now;
    logic [47:0] bounds [4];
    grant_t      outcome_q [$];
    int          errors;
    int          n_results;
    int          n_empty;
    int          n_full;
    int          n_cmd [4];

    function new();
      depth_now = 0;
      errors    = 0;
      n_results = 0;
      n_empty   = 0;
      n_full    = 0;
      foreach (bounds[i]) bounds[i] = '0;
      foreach (n_cmd[i]) n_cmd[i] = 0;
    endfunction

    function void write_reg(pfsa_pkg::cfg_idx_e idx, logic [47:0] value);
      bounds[idx] = value;
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    // Convert an inclusive byte range into the page numbers it excludes: start rounded up, end taken as its own page.
    function bit excluded_pages(logic [63:0] s, logic [63:0] e,
                                output logic [63:0] lo, output logic [63:0] hi);
      lo = (s >> 12) + ((s[11:0] != 12'h0) ? 64'd1 : 64'd0);
      hi = e >> 12;
      return !(s > e || lo > hi);
    endfunction

    function logic [63:0] next_free_pfn(logic [63:0] p);
      logic [63:0] sl, sh, kl, kh;
      bit          hs, hk, moved;
      hs = excluded_pages(bounds[pfsa_pkg::CFG_STORE_START], bounds[pfsa_pkg::CFG_STORE_END],
                          sl, sh);
      hk = excluded_pages(bounds[pfsa_pkg::CFG_KERNEL_FIRST], bounds[pfsa_pkg::CFG_KERNEL_LAST],
                          kl, kh);
      moved = 1'b1;
      while (moved) begin
        moved = 1'b0;
        if (hs && p >= sl && p <= sh) begin
          p = sh + 1;
          moved = 1'b1;
        end
        if (hk && p >= kl && p <= kh) begin
          p = kh + 1;
          moved = 1'b1;
        end
      end
      return p;
    endfunction

    function bit push_frame(logic [63:0] pfn);
      if (depth_now >= STACK_DEPTH) return 1'b0;
      frames[depth_now] = pfn[35:0];
      depth_now++;
      return 1'b1;
    endfunction

    function void note_command(request_t r);
      grant_t      g;
      logic [63:0] b, l, p, endp;
      g.page   = '0;
      g.status = pfsa_pkg::STAT_OK;
      b = 64'(r.base);
      l = 64'(r.len);
      n_cmd[r.cmd]++;
      case (r.cmd)
        pfsa_pkg::CMD_ADD: begin
          if (r.usable) begin
            p    = b >> 12;
            endp = (b >> 12) + (l >> 12) + (((b & 64'hfff) + (l & 64'hfff) + 64'hfff) >> 12);
            if (endp > PFN_LIMIT) endp = PFN_LIMIT;
            if (p < LOW_PFN) p = LOW_PFN;
            p = next_free_pfn(p);
            while (p < endp) begin
              if (!push_frame(p)) begin
                g.status = pfsa_pkg::STAT_FULL;
                break;
              end
              p = next_free_pfn(p + 1);
            end
          end
        end
        pfsa_pkg::CMD_ALLOC: begin
          if (depth_now == 0) begin
            g.status = pfsa_pkg::STAT_EMPTY;
          end else begin
            depth_now--;
            g.page = {frames[depth_now], 12'h000};
          end
        end
        pfsa_pkg::CMD_FREE: begin
          if (r.freed != '0 && !push_frame(64'(r.freed) >> 12)) g.status = pfsa_pkg::STAT_FULL;
        end
        default: ;
      endcase
      if (g.status == pfsa_pkg::STAT_EMPTY) n_empty++;
      if (g.status == pfsa_pkg::STAT_FULL) n_full++;
      g.count = depth_now[12:0];
      outcome_q.push_back(g);
    endfunction

    function void flag(string field, logic [47:0] want, logic [47:0] got);
      errors++;
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    endfunction

    function void check_result(logic [47:0] page, logic [1:0] status, logic [12:0] count);
      grant_t g;
      n_results++;
      if (outcome_q.size() == 0) begin
        errors++;
        $error("result strobed with no command outstanding");
        return;
      end
      g = outcome_q.pop_front();
      if (page !== g.page) flag("page_address", g.page, page);
      if (status !== g.status) flag("status", 48'(g.status), 48'(status));
      if (count !== g.count) flag("free_count", 48'(g.count), 48'(count));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic                  done_o;
  logic [1:0]            cmd_i;
  logic [ADDR_BITS-1:0]  region_base_i;
  logic [ADDR_BITS-1:0]  region_length_i;
  logic                  region_usable_i;
  logic [ADDR_BITS-1:0]  freed_address_i;
  logic [ADDR_BITS-1:0]  page_address_o;
  logic [1:0]            status_o;
  logic [12:0]           free_count_o;
  logic                  cfg_we_i;
  logic [1:0]            cfg_idx_i;
  logic [ADDR_BITS-1:0]  cfg_data_i;

  frame_stack_mirror ledger = new();
  int                quiet = 0;
  int                n_settings = 0;

  page_frame_stack_allocator #(
    .STACK_DEPTH(STACK_DEPTH),
    .ADDR_BITS  (ADDR_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .done_o         (done_o),
    .cmd_i          (cmd_i),
    .region_base_i  (region_base_i),
    .region_length_i(region_length_i),
    .region_usable_i(region_usable_i),
    .freed_address_i(freed_address_i),
    .page_address_o (page_address_o),
    .status_o       (status_o),
    .free_count_o   (free_count_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Sample pre-edge values: check grants, note accepted commands and register writes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) ledger.check_result(page_address_o, status_o, free_count_o);
      if (start && !busy)
        ledger.note_command('{cmd: pfsa_pkg::cmd_e'(cmd_i), base: region_base_i,
                              len: region_length_i, usable: region_usable_i,
                              freed: freed_address_i});
      if (cfg_we_i) ledger.write_reg(pfsa_pkg::cfg_idx_e'(cfg_idx_i), cfg_data_i);
      quiet <= (done_o || (start && !busy)) ? 0 : quiet + 1;
    end
  end

  initial begin
    while (quiet < WATCHDOG) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic request_t mk_req(pfsa_pkg::cmd_e c, logic [47:0] b, logic [47:0] l,
                                      logic u, logic [47:0] f);
    return '{cmd: c, base: b, len: l, usable: u, freed: f};
  endfunction

  function automatic request_t rand_request();
    request_t r;
    int       sel, lsel, alloc_pct, pick;
    r.base   = rand48();
    r.len    = rand48();
    r.usable = 1'($urandom_range(1));
    r.freed  = rand48();
    // lean toward alloc near full so the count keeps moving
    alloc_pct = (ledger.depth_now < 64) ? 30 : (ledger.depth_now > 3500) ? 65 : 42;
    pick = $urandom_range(99);
    if (pick < 3) r.cmd = pfsa_pkg::CMD_NONE;
    else if (pick < 3 + alloc_pct) r.cmd = pfsa_pkg::CMD_ALLOC;
    else if (pick < 23 + alloc_pct) r.cmd = pfsa_pkg::CMD_FREE;
    else r.cmd = pfsa_pkg::CMD_ADD;
    if (r.cmd == pfsa_pkg::CMD_ADD) begin
      sel  = $urandom_range(99);
      lsel = $urandom_range(99);
      r.usable = ($urandom_range(99) < 85);
      if (sel < 70) r.base = 48'($urandom_range(0, 32'h17f_ffff));
      else if (sel < 80) r.base = ADDR_TOP - 48'($urandom_range(0, 32'h3_ffff));
      else if (sel < 90) r.base = rand48();
      else r.base = 48'($urandom_range(0, 32'hf_ffff));
      if (lsel < 90) begin
        r.len = 48'($urandom_range(0, 16384));
      end else if (lsel < 93) begin
        r.len = 48'($urandom_range(16000000, 24000000));
      end else begin
        // huge lengths walk only when clipped at the top of the address space
        r.len = rand48();
        if (sel < 70 || sel >= 80) r.usable = 1'b0;
      end
    end else if (r.cmd == pfsa_pkg::CMD_FREE) begin
      sel = $urandom_range(99);
      if (sel < 10) r.freed = '0;
      else if (sel < 20) r.freed = 48'($urandom_range(1, 4095));
      else if (sel < 50) r.freed = 48'($urandom_range(32'h10_0000, 32'h17f_ffff));
    end
    return r;
  endfunction

  task automatic send(input request_t r);
    cmd_i           <= r.cmd;
    region_base_i   <= r.base;
    region_length_i <= r.len;
    region_usable_i <= r.usable;
    freed_address_i <= r.freed;
    start           <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  // Hold off the sender until every outstanding grant has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_bounds(input logic [47:0] s0, input logic [47:0] s1,
                              input logic [47:0] k0, input logic [47:0] k1);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= pfsa_pkg::CFG_STORE_START;
    cfg_data_i <= s0;
    @(posedge clk_i);
    cfg_idx_i  <= pfsa_pkg::CFG_STORE_END;
    cfg_data_i <= s1;
    @(posedge clk_i);
    cfg_idx_i  <= pfsa_pkg::CFG_KERNEL_FIRST;
    cfg_data_i <= k0;
    @(posedge clk_i);
    cfg_idx_i  <= pfsa_pkg::CFG_KERNEL_LAST;
    cfg_data_i <= k1;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    n_settings++;
  endtask

  task automatic rand_range(output logic [47:0] lo, output logic [47:0] hi);
    int mode;
    mode = $urandom_range(7);
    if (mode == 0) begin
      lo = rand48();
      hi = rand48();
    end else begin
      lo = (mode == 1) ? rand48() : 48'($urandom_range(0, 32'hff_ffff));
      hi = lo + 48'($urandom_range(0, 32'h4_0000));
      // an inverted range excludes nothing
      if (mode == 2) hi = lo - 48'($urandom_range(1, 32'h1_0000));
    end
  endtask

  task automatic run_phase(input int n, input int idle_pct);
    int gap;
    for (int i = 0; i < n; i++) begin
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 30) gap++;
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      send(rand_request());
    end
  endtask

  initial begin
    int          idle_pct [8];
    logic [47:0] s0, s1, k0, k1;
    idle_pct        = '{0, 68, 27, 0, 68, 27, 68, 0};
    rst_ni          <= 1'b0;
    start           <= 1'b0;
    cmd_i           <= pfsa_pkg::CMD_NONE;
    region_base_i   <= '0;
    region_length_i <= '0;
    region_usable_i <= 1'b0;
    freed_address_i <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= pfsa_pkg::CFG_STORE_START;
    cfg_data_i      <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // kernel range starts mid-page, so its first page stays eligible
    write_bounds(48'h18_0000, 48'h18_1fff, 48'h18_3800, 48'h18_5fff);
    send(mk_req(pfsa_pkg::CMD_ALLOC, '0, '0, 1'b0, '0));
    send(mk_req(pfsa_pkg::CMD_FREE, '0, '0, 1'b0, '0));
    send(mk_req(pfsa_pkg::CMD_NONE, ADDR_TOP, ADDR_TOP, 1'b1, ADDR_TOP));
    send(mk_req(pfsa_pkg::CMD_FREE, '0, '0, 1'b0, 48'h123));
    send(mk_req(pfsa_pkg::CMD_ALLOC, '0, '0, 1'b0, '0));
    send(mk_req(pfsa_pkg::CMD_ADD, 48'h17_f800, 48'h8000, 1'b1, '0));
    send(mk_req(pfsa_pkg::CMD_ADD, 48'h20_0000, 48'h10_0000, 1'b0, '0));
    send(mk_req(pfsa_pkg::CMD_ADD, '0, 48'h10_2000, 1'b1, '0));
    send(mk_req(pfsa_pkg::CMD_ADD, 48'h30_0000, '0, 1'b1, '0));
    send(mk_req(pfsa_pkg::CMD_ADD, 48'h30_0000, 48'h1, 1'b1, '0));
    send(mk_req(pfsa_pkg::CMD_ADD, ADDR_TOP - 48'h1fff, ADDR_TOP, 1'b1, '0));
    send(mk_req(pfsa_pkg::CMD_ADD, ADDR_TOP, '0, 1'b1, '0));
    send(mk_req(pfsa_pkg::CMD_FREE, '0, '0, 1'b0, ADDR_TOP));
    send(mk_req(pfsa_pkg::CMD_ALLOC, '0, '0, 1'b0, '0));
    send(mk_req(pfsa_pkg::CMD_ALLOC, '0, '0, 1'b0, '0));
    send(mk_req(pfsa_pkg::CMD_ADD, 48'h100_0000, 48'h140_0000, 1'b1, '0));
    send(mk_req(pfsa_pkg::CMD_FREE, '0, '0, 1'b0, 48'h1234_5678));
    send(mk_req(pfsa_pkg::CMD_ADD, 48'h40_0000, 48'h3000, 1'b1, '0));
    send(mk_req(pfsa_pkg::CMD_NONE, '0, '0, 1'b0, '0));
    send(mk_req(pfsa_pkg::CMD_ALLOC, '0, '0, 1'b0, '0));

    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      case (ph)
        0: write_bounds('0, '0, '0, '0);
        1: write_bounds('0, ADDR_TOP, ADDR_TOP, ADDR_TOP);
        2: write_bounds(ADDR_TOP, ADDR_TOP, '0, ADDR_TOP);
        default: begin
          rand_range(s0, s1);
          rand_range(k0, k1);
          write_bounds(s0, s1, k0, k1);
        end
      endcase
      run_phase(205, idle_pct[ph]);
    end

    drain_results();
    repeat (16) @(posedge clk_i);
    $display("Ran %0d commands (%0d add, %0d alloc, %0d free, %0d unused), %0d grants checked,",
             ledger.n_cmd[pfsa_pkg::CMD_ADD] + ledger.n_cmd[pfsa_pkg::CMD_ALLOC] +
             ledger.n_cmd[pfsa_pkg::CMD_FREE] + ledger.n_cmd[pfsa_pkg::CMD_NONE],
             ledger.n_cmd[pfsa_pkg::CMD_ADD], ledger.n_cmd[pfsa_pkg::CMD_ALLOC],
             ledger.n_cmd[pfsa_pkg::CMD_FREE], ledger.n_cmd[pfsa_pkg::CMD_NONE],
             ledger.n_results);
    $display("stack empty on %0d allocs, full on %0d pushes, across %0d exclusion settings.",
             ledger.n_empty, ledger.n_full, n_settings);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/pfsa_pkg.sv
design/pfsa_ram.sv
design/page_frame_stack_allocator.sv
verif/tb_page_frame_stack_allocator.sv
